/* sv/gtf_pkg.sv */
package gtf_pkg;

    localparam int CHANNELS_BUILT = 32;
    localparam int STAGES       = 4;
    localparam int SLOTS_PER_CH = 2 + 3 * STAGES;
    localparam int CH_W         = $clog2(CHANNELS_BUILT);
    localparam int STAGE_W      = $clog2(STAGES);
    localparam int SLOT_W       = 4;
    localparam int CFG_W        = 7;
    localparam int CADDR_W      = CH_W + SLOT_W;
    localparam int SADDR_W      = CH_W + STAGE_W + 1;
    localparam int CDEPTH       = CHANNELS_BUILT * (2 ** SLOT_W);
    localparam int SDEPTH       = CHANNELS_BUILT * STAGES * 2;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;
    localparam int PHASE_W      = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [SLOT_W-1:0] SLOT_A1 = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_A2 = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_B0 = SLOT_W'(2);

    // phases of one section
    localparam logic [PHASE_W-1:0] PH_RD_B0  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_MUL_B0 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_MUL_B1 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_MUL_B2 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_MUL_A1 = 3'd4;
    localparam logic [PHASE_W-1:0] PH_MUL_A2 = 3'd5;
    localparam logic [PHASE_W-1:0] PH_WR_S0  = 3'd6;
    localparam logic [PHASE_W-1:0] PH_WR_S1  = 3'd7;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CH_A1,
        BK_CH_A2,
        BK_STAGE,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic                func;
        logic [5:0]          coeff_channel;
        logic [3:0]          coeff_slot;
        logic signed [31:0]  coeff_value;
        logic signed [15:0]  sample;
    } in_item_t;

    typedef struct packed {
        logic [5:0]          channel;
        logic signed [23:0]  value;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic                is_load;
        logic [CH_W-1:0]     ch;
        logic [SLOT_W-1:0]   slot;
        logic signed [31:0]  value;
        logic signed [15:0]  sample;
        logic [CH_W-1:0]     last_ch;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } qhead_t;

    function automatic logic [SLOT_W-1:0] stage_slot(logic [STAGE_W-1:0] st, int k);
        stage_slot = SLOT_W'(int'(SLOT_B0) + 3 * int'(st) + k);
    endfunction

    function automatic logic signed [47:0] sat48(logic signed [53:0] v);
        if (v[53:47] == {7{v[53]}})
        begin
            sat48 = v[47:0];
        end
        else
        begin
            sat48 = v[53] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end
    endfunction

    function automatic logic signed [23:0] sat24(logic signed [31:0] v);
        if (v[31:23] == {9{v[31]}})
        begin
            sat24 = v[23:0];
        end
        else
        begin
            sat24 = v[31] ? {1'b1, 23'b0} : {1'b0, {23{1'b1}}};
        end
    endfunction

endpackage

/* sv/gtf_front.sv */
module gtf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gtf_pkg::in_item_t  in_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [gtf_pkg::CFG_W-1:0] cfg_data,
    output gtf_pkg::qhead_t    qhead,
    input  logic               pop
);

    logic [gtf_pkg::CFG_W-1:0]  cfg_reg;
    gtf_pkg::cmd_t              q_mem [gtf_pkg::QDEPTH];
    logic [gtf_pkg::QPTR_W-1:0] wptr_reg;
    logic [gtf_pkg::QPTR_W-1:0] rptr_reg;
    logic [gtf_pkg::QCNT_W-1:0] cnt_reg;
    logic [gtf_pkg::QCNT_W-1:0] cnt_next;
    logic [gtf_pkg::CFG_W-1:0]  n_eff;
    logic                       accept;
    logic                       push;
    logic                       do_pop;
    gtf_pkg::cmd_t              cmd;

    assign cfg_ready = 1'b1;
    assign in_ready  = (cnt_reg != gtf_pkg::QCNT_W'(gtf_pkg::QDEPTH));
    assign accept    = in_valid && in_ready;
    assign do_pop    = pop && (cnt_reg != '0);

    // clamp channel count, classify the item
    always_comb
    begin
        n_eff = (cfg_reg > gtf_pkg::CFG_W'(gtf_pkg::CHANNELS_BUILT))
              ? gtf_pkg::CFG_W'(gtf_pkg::CHANNELS_BUILT) : cfg_reg;
        cmd.is_load = (in_data.func == gtf_pkg::FUNC_LOAD);
        cmd.ch      = gtf_pkg::CH_W'(in_data.coeff_channel);
        cmd.slot    = in_data.coeff_slot;
        cmd.value   = in_data.coeff_value;
        cmd.sample  = in_data.sample;
        cmd.last_ch = gtf_pkg::CH_W'(n_eff - gtf_pkg::CFG_W'(1));
        if (in_data.func == gtf_pkg::FUNC_LOAD)
        begin
            push = accept
                && (7'(in_data.coeff_channel) < 7'(gtf_pkg::CHANNELS_BUILT))
                && (5'(in_data.coeff_slot) < 5'(gtf_pkg::SLOTS_PER_CH));
        end
        else
        begin
            push = accept && (n_eff != '0);
        end
        cnt_next = cnt_reg + gtf_pkg::QCNT_W'(push) - gtf_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= gtf_pkg::CFG_RESET;
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_reg <= cfg_data;
            end
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wptr_reg] <= cmd;
        end
    end

    assign qhead.valid = (cnt_reg != '0);
    assign qhead.cmd   = q_mem[rptr_reg];

endmodule

/* sv/gtf_back.sv */
module gtf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  gtf_pkg::qhead_t    qhead,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output gtf_pkg::out_item_t out_data
);

    gtf_pkg::back_state_t state_reg;
    gtf_pkg::back_state_t state_next;

    logic [gtf_pkg::CH_W-1:0]    ch_reg;
    logic [gtf_pkg::CH_W-1:0]    last_ch_reg;
    logic [gtf_pkg::STAGE_W-1:0] st_reg;
    logic [gtf_pkg::PHASE_W-1:0] ph_reg;
    logic signed [15:0]          sample_reg;
    logic signed [47:0]          x_reg;
    logic signed [47:0]          y_reg;
    logic signed [31:0]          a1_reg;
    logic signed [31:0]          a2_reg;
    logic signed [47:0]          s0_reg;
    logic signed [47:0]          s1_reg;
    logic signed [53:0]          acc1_reg;
    logic signed [53:0]          acc2_reg;
    logic signed [55:0]          phi_reg;
    logic signed [56:0]          plo_reg;
    logic signed [51:0]          q_reg;
    logic signed [31:0]          coef_rd_reg;
    logic signed [47:0]          st_rd_reg;
    logic                        out_valid_reg;
    gtf_pkg::out_item_t          out_reg;

    logic signed [31:0] cmem [gtf_pkg::CDEPTH];
    logic signed [47:0] smem [gtf_pkg::SDEPTH];
    logic [gtf_pkg::SDEPTH-1:0]  sval_reg;

    logic                        cwe;
    logic [gtf_pkg::CADDR_W-1:0] craddr;
    logic [gtf_pkg::CADDR_W-1:0] cwaddr;
    logic [gtf_pkg::SADDR_W-1:0] sraddr;
    logic                        swe;
    logic [gtf_pkg::SADDR_W-1:0] swaddr;
    logic signed [47:0]          swdata;
    logic signed [31:0]          mul_c;
    logic signed [47:0]          mul_x;
    logic                        emit;
    logic                        out_free;
    logic                        ch_last;
    logic                        st_last;
    logic signed [57:0]          qsum;
    logic signed [53:0]          q_ext;

    assign out_free = !out_valid_reg || out_ready;
    assign ch_last  = (ch_reg == last_ch_reg);
    assign st_last  = (st_reg == gtf_pkg::STAGE_W'(gtf_pkg::STAGES - 1));
    assign cwaddr   = {qhead.cmd.ch, qhead.cmd.slot};
    assign q_ext    = {{2{q_reg[51]}}, q_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gtf_pkg::BK_IDLE:
            begin
                if (qhead.valid && !qhead.cmd.is_load)
                begin
                    state_next = gtf_pkg::BK_CH_A1;
                end
            end
            gtf_pkg::BK_CH_A1: state_next = gtf_pkg::BK_CH_A2;
            gtf_pkg::BK_CH_A2: state_next = gtf_pkg::BK_STAGE;
            gtf_pkg::BK_STAGE:
            begin
                if (ph_reg == gtf_pkg::PH_WR_S1 && st_last)
                begin
                    state_next = gtf_pkg::BK_EMIT;
                end
            end
            gtf_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ch_last ? gtf_pkg::BK_IDLE : gtf_pkg::BK_CH_A1;
                end
            end
            default: state_next = gtf_pkg::BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop    = 1'b0;
        cwe    = 1'b0;
        emit   = 1'b0;
        swe    = 1'b0;
        craddr = {ch_reg, gtf_pkg::SLOT_A1};
        sraddr = {ch_reg, st_reg, 1'b0};
        swaddr = {ch_reg, st_reg, 1'b0};
        swdata = gtf_pkg::sat48(acc1_reg - q_ext);
        mul_c  = coef_rd_reg;
        mul_x  = x_reg;
        unique case (state_reg)
            gtf_pkg::BK_IDLE:
            begin
                pop = qhead.valid;
                cwe = qhead.valid && qhead.cmd.is_load;
            end
            gtf_pkg::BK_CH_A1: craddr = {ch_reg, gtf_pkg::SLOT_A1};
            gtf_pkg::BK_CH_A2: craddr = {ch_reg, gtf_pkg::SLOT_A2};
            gtf_pkg::BK_STAGE:
            begin
                unique case (ph_reg)
                    gtf_pkg::PH_RD_B0:
                    begin
                        craddr = {ch_reg, gtf_pkg::stage_slot(st_reg, 0)};
                        sraddr = {ch_reg, st_reg, 1'b0};
                    end
                    gtf_pkg::PH_MUL_B0:
                    begin
                        craddr = {ch_reg, gtf_pkg::stage_slot(st_reg, 1)};
                        sraddr = {ch_reg, st_reg, 1'b1};
                    end
                    gtf_pkg::PH_MUL_B1:
                    begin
                        craddr = {ch_reg, gtf_pkg::stage_slot(st_reg, 2)};
                    end
                    gtf_pkg::PH_MUL_B2: ;
                    gtf_pkg::PH_MUL_A1:
                    begin
                        mul_c = a1_reg;
                        mul_x = y_reg;
                    end
                    gtf_pkg::PH_MUL_A2:
                    begin
                        mul_c = a2_reg;
                        mul_x = y_reg;
                    end
                    gtf_pkg::PH_WR_S0:
                    begin
                        swe    = 1'b1;
                        swdata = gtf_pkg::sat48(acc1_reg - q_ext);
                    end
                    gtf_pkg::PH_WR_S1:
                    begin
                        swe    = 1'b1;
                        swaddr = {ch_reg, st_reg, 1'b1};
                        swdata = gtf_pkg::sat48(acc2_reg - q_ext);
                    end
                    default: ;
                endcase
            end
            gtf_pkg::BK_EMIT: emit = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gtf_pkg::BK_IDLE;
            ch_reg        <= '0;
            st_reg        <= '0;
            ph_reg        <= '0;
            sval_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (swe)
            begin
                sval_reg[swaddr] <= 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == gtf_pkg::BK_IDLE)
            begin
                ch_reg <= '0;
            end
            else if (emit && !ch_last)
            begin
                ch_reg <= ch_reg + 1'b1;
            end
            if (state_reg == gtf_pkg::BK_CH_A2)
            begin
                st_reg <= '0;
            end
            else if (state_reg == gtf_pkg::BK_STAGE && ph_reg == gtf_pkg::PH_WR_S1)
            begin
                st_reg <= st_reg + 1'b1;
            end
            ph_reg <= (state_reg == gtf_pkg::BK_STAGE) ? ph_reg + 1'b1 : '0;
        end
    end

    // combine the two partial products: floor(c * x / 2^30)
    assign qsum = $signed({{2{phi_reg[55]}}, phi_reg})
                + $signed({{25{plo_reg[56]}}, plo_reg[56:24]});

    always_ff @(posedge clk)
    begin
        coef_rd_reg <= cmem[craddr];
        if (cwe)
        begin
            cmem[cwaddr] <= qhead.cmd.value;
        end
        st_rd_reg <= sval_reg[sraddr] ? smem[sraddr] : '0;
        if (swe)
        begin
            smem[swaddr] <= swdata;
        end

        phi_reg <= mul_c * $signed(mul_x[47:24]);
        plo_reg <= mul_c * $signed({1'b0, mul_x[23:0]});
        q_reg   <= qsum[57:6];

        if (state_reg == gtf_pkg::BK_IDLE && pop && !qhead.cmd.is_load)
        begin
            sample_reg  <= qhead.cmd.sample;
            last_ch_reg <= qhead.cmd.last_ch;
        end
        if (state_reg == gtf_pkg::BK_CH_A2)
        begin
            a1_reg <= coef_rd_reg;
            x_reg  <= {{16{sample_reg[15]}}, sample_reg, 16'b0};
        end
        if (state_reg == gtf_pkg::BK_STAGE)
        begin
            unique case (ph_reg)
                gtf_pkg::PH_RD_B0:
                begin
                    if (st_reg == '0)
                    begin
                        a2_reg <= coef_rd_reg;
                    end
                end
                gtf_pkg::PH_MUL_B0: s0_reg <= st_rd_reg;
                gtf_pkg::PH_MUL_B1: s1_reg <= st_rd_reg;
                gtf_pkg::PH_MUL_B2:
                    y_reg <= gtf_pkg::sat48(q_ext + {{6{s0_reg[47]}}, s0_reg});
                gtf_pkg::PH_MUL_A1: acc1_reg <= q_ext + {{6{s1_reg[47]}}, s1_reg};
                gtf_pkg::PH_MUL_A2: acc2_reg <= q_ext;
                gtf_pkg::PH_WR_S0: ;
                gtf_pkg::PH_WR_S1: x_reg <= y_reg;
                default: ;
            endcase
        end
        if (emit)
        begin
            out_reg.channel <= 6'(ch_reg);
            out_reg.value   <= gtf_pkg::sat24(x_reg[47:16]);
            out_reg.last    <= ch_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* sv/gammatone_filterbank.sv */
// Gammatone filter bank: every channel runs the same audio sample through
// four cascaded second-order sections that share the channel's a1 a2.
// in channel (in_valid/in_ready/in_data): func 0 loads one Q2.30
//   coefficient word, func 1 filters one 16-bit sample. Loads to a channel
//   or slot out of range are dropped, as are samples while the channel
//   count is zero.
// cfg channel (cfg_valid/cfg_ready/cfg_data): channel count, always ready;
//   write it only while the block is idle. Counts above 32 act as 32.
// out channel (out_valid/out_ready/out_data): one item per channel in
//   channel order, last set on the final one.
// Items pass a two-entry command queue, so up to two items are taken while
// the filter engine is busy. In the engine a sample runs for each channel
// in turn: two coefficient fetches, the sections in phases set by the
// single multiply pair and one state memory port, then one output step.
// A load is written while the engine is idle. When the receiver stalls,
// the engine holds at its output step and the queue fills, then in_ready
// drops. Reset clears the queue, sets the count to 32 and zeroes all
// filter state at once through per-word valid bits; coefficients must be
// loaded before use.
module gammatone_filterbank (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gtf_pkg::in_item_t  in_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [gtf_pkg::CFG_W-1:0] cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output gtf_pkg::out_item_t out_data
);

    gtf_pkg::qhead_t qhead;
    logic            pop;

    // accept, classify and queue items
    gtf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .qhead     (qhead),
        .pop       (pop)
    );

    // run loads and filter passes
    gtf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qhead     (qhead),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // the engine takes a command only when one is queued
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> qhead.valid)
        else $error("pop from empty queue");

    // a full queue always shows a command at its head
    a_full_head: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> qhead.valid)
        else $error("queue full but head not valid");

    // results stay within the built channels
    a_out_channel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.channel < 6'(gtf_pkg::CHANNELS_BUILT)))
        else $error("result channel out of range");

    // a new result never follows a result that was not yet taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_data))
        else $error("result changed while stalled");

endmodule

/* tb/sv/gammatone_filterbank_checker.sv */
`timescale 1ns / 100ps

module gammatone_filterbank_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  gtf_pkg::in_item_t          in_data,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [gtf_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  gtf_pkg::out_item_t         out_data,
    output int                         errors,
    output int                         pending
);

    logic signed [31:0] coef_table [gtf_pkg::CHANNELS_BUILT][gtf_pkg::SLOTS_PER_CH];
    logic signed [47:0] section_state [gtf_pkg::CHANNELS_BUILT][gtf_pkg::STAGES][2];
    logic [gtf_pkg::CFG_W-1:0] channel_count;
    gtf_pkg::out_item_t        channel_outputs_due [$];

    localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN48 = -MAX48 - 64'sd1;
    localparam logic signed [63:0] MAX24 = 64'sh7F_FFFF;
    localparam logic signed [63:0] MIN24 = -MAX24 - 64'sd1;

    // floor(c * x / 2^30), exact
    function automatic logic signed [63:0] coef_mul(logic signed [31:0] c,
                                                    logic signed [47:0] x);
        logic signed [79:0] cw;
        logic signed [79:0] xw;
        logic signed [79:0] p;
        cw = c;
        xw = x;
        p = cw * xw;
        return 64'(p >>> 30);
    endfunction

    function automatic logic signed [63:0] clip(logic signed [63:0] v,
                                                logic signed [63:0] lo,
                                                logic signed [63:0] hi);
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    task automatic filter_sample(input logic signed [15:0] smp);
        int n;
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic signed [63:0] acc;
        gtf_pkg::out_item_t r;
        n = (channel_count > gtf_pkg::CHANNELS_BUILT)
            ? gtf_pkg::CHANNELS_BUILT : int'(channel_count);
        for (int ch = 0; ch < n; ch++)
        begin
            x = 48'(smp) <<< 16;
            for (int s = 0; s < gtf_pkg::STAGES; s++)
            begin
                acc = coef_mul(coef_table[ch][2 + 3 * s], x) + section_state[ch][s][0];
                y = 48'(clip(acc, MIN48, MAX48));
                acc = coef_mul(coef_table[ch][3 + 3 * s], x)
                      - coef_mul(coef_table[ch][0], y) + section_state[ch][s][1];
                section_state[ch][s][0] = 48'(clip(acc, MIN48, MAX48));
                acc = coef_mul(coef_table[ch][4 + 3 * s], x)
                      - coef_mul(coef_table[ch][1], y);
                section_state[ch][s][1] = 48'(clip(acc, MIN48, MAX48));
                x = y;
            end
            acc = 64'(x) >>> 16;
            r.channel = 6'(ch);
            r.value   = 24'(clip(acc, MIN24, MAX24));
            r.last    = (ch + 1 == n);
            channel_outputs_due.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gtf_pkg::out_item_t want;
        int bad;
        bad = 0;
        if (!rst_n)
        begin
            channel_outputs_due.delete();
            channel_count = gtf_pkg::CFG_RESET;
            errors <= 0;
            for (int c = 0; c < gtf_pkg::CHANNELS_BUILT; c++)
            begin
                for (int k = 0; k < gtf_pkg::SLOTS_PER_CH; k++)
                begin
                    coef_table[c][k] = '0;
                end
                for (int s = 0; s < gtf_pkg::STAGES; s++)
                begin
                    section_state[c][s][0] = '0;
                    section_state[c][s][1] = '0;
                end
            end
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (channel_outputs_due.size() == 0)
                begin
                    $display("%0t: unexpected output item ch=%0d value=%0d last=%0d",
                             $time, out_data.channel, out_data.value, out_data.last);
                    bad++;
                end
                else
                begin
                    want = channel_outputs_due.pop_front();
                    if (want.channel !== out_data.channel)
                    begin
                        $display("%0t: channel expected %0d actual %0d",
                                 $time, want.channel, out_data.channel);
                        bad++;
                    end
                    if (want.value !== out_data.value)
                    begin
                        $display("%0t: value ch %0d expected %0d actual %0d",
                                 $time, want.channel, want.value, out_data.value);
                        bad++;
                    end
                    if (want.last !== out_data.last)
                    begin
                        $display("%0t: last ch %0d expected %0d actual %0d",
                                 $time, want.channel, want.last, out_data.last);
                        bad++;
                    end
                end
            end
            if (bad != 0)
            begin
                errors <= errors + bad;
            end
            if (cfg_valid && cfg_ready)
            begin
                channel_count = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                if (in_data.func == gtf_pkg::FUNC_LOAD)
                begin
                    if (in_data.coeff_channel < gtf_pkg::CHANNELS_BUILT
                        && in_data.coeff_slot < gtf_pkg::SLOTS_PER_CH)
                    begin
                        coef_table[in_data.coeff_channel][in_data.coeff_slot] =
                            in_data.coeff_value;
                    end
                end
                else
                begin
                    filter_sample(in_data.sample);
                end
            end
        end
        pending <= channel_outputs_due.size();
    end

endmodule

/* tb/sv/gammatone_filterbank_test.sv */
`timescale 1ns / 100ps

module gammatone_filterbank_test;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    gtf_pkg::in_item_t           in_data;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [gtf_pkg::CFG_W-1:0]   cfg_data;
    logic                        out_valid;
    logic                        out_ready;
    gtf_pkg::out_item_t          out_data;
    int                          errors;
    int                          pending;

    // set while valid is left high for the next item
    bit                  valid_held;
    // stretches with no idling on either side
    bit                  no_idle;
    int                  quiet_cycles;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 110;

    gammatone_filterbank u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    gammatone_filterbank_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_idle)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(20, 200);
    endfunction

    // Receiver: alternate ready runs and stalls (a stall may be skipped); each
    // waits on the clock, so out_ready gets a single update per edge.
    initial
    begin
        int run;
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = no_idle ? 400 : $urandom_range(1, 12);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Hold the item until in_ready is seen at an edge, then idle a while.
    task automatic send_item(input gtf_pkg::in_item_t it);
        int gap;
        in_data  <= it;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        gap = pick_gap();
        valid_held = (gap == 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_load(input int ch, input int slot, input logic [31:0] v);
        gtf_pkg::in_item_t it;
        it.func          = gtf_pkg::FUNC_LOAD;
        it.coeff_channel = 6'(ch);
        it.coeff_slot    = 4'(slot);
        it.coeff_value   = v;
        it.sample        = 16'($urandom);
        send_item(it);
    endtask

    task automatic send_sample(input logic [15:0] s);
        gtf_pkg::in_item_t it;
        it.func          = gtf_pkg::FUNC_SAMPLE;
        it.coeff_channel = 6'($urandom);
        it.coeff_slot    = 4'($urandom);
        it.coeff_value   = 32'($urandom);
        it.sample        = s;
        send_item(it);
    endtask

    // Drop valid and wait until every expected output has come out, then a
    // margin for a load still in the engine.
    task automatic wait_idle();
        if (valid_held)
        begin
            in_valid <= 1'b0;
            valid_held = 1'b0;
        end
        repeat (2) @(posedge clk);
        do
        begin
            while (pending != 0)
            begin
                @(posedge clk);
            end
            repeat (40) @(posedge clk);
        end
        while (pending != 0);
    endtask

    task automatic write_count(input int n);
        wait_idle();
        cfg_data  <= gtf_pkg::CFG_W'(n);
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Coefficient: mostly moderate so the filters stay in range, sometimes
    // full scale to drive the states into saturation.
    function automatic logic [31:0] pick_coef();
        logic signed [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 7) == 0)
        begin
            return v;
        end
        return v >>> $urandom_range(2, 5);
    endfunction

    // Count cycles with no handshake anywhere; abort when it runs too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int counts [5];
        counts       = '{64, 7, 127, 33, 32};
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        valid_held   = 1'b0;
        no_idle      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one channel, extreme coefficients and samples.
        write_count(1);
        send_load(0, gtf_pkg::SLOT_A1, 32'h0);
        send_load(0, gtf_pkg::SLOT_A2, 32'h0);
        send_load(0, 2, 32'h7FFF_FFFF);
        send_load(0, 3, 32'h8000_0000);
        send_load(0, 4, 32'h0);
        for (int s = 1; s < gtf_pkg::STAGES; s++)
        begin
            send_load(0, 2 + 3 * s, 32'h4000_0000);
            send_load(0, 3 + 3 * s, 32'h0);
            send_load(0, 4 + 3 * s, 32'h0);
        end
        // out of range loads are dropped
        send_load(63, 0, 32'hFFFF_FFFF);
        send_load(5, 15, 32'h7FFF_FFFF);
        send_load(32, 14, 32'h8000_0000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        // unstable feedback pushes the states into saturation
        send_load(0, gtf_pkg::SLOT_A1, 32'h8000_0000);
        send_load(0, gtf_pkg::SLOT_A2, 32'h7FFF_FFFF);
        repeat (3) send_sample(16'sh7FFF);
        send_sample(16'sh8000);

        // zero channels: samples give nothing
        write_count(0);
        send_sample(16'sh7FFF);
        send_sample(16'h1234);

        // Fill the whole table before running all channels.
        for (int c = 0; c < gtf_pkg::CHANNELS_BUILT; c++)
        begin
            for (int k = 0; k < gtf_pkg::SLOTS_PER_CH; k++)
            begin
                send_load(c, k, pick_coef());
            end
        end

        // Random phases, each after an idle point with a new channel count.
        for (int ph = 0; ph < 5; ph++)
        begin
            write_count(counts[ph]);
            no_idle = (ph == 2);
            for (int i = 0; i < RANDOM_ITEMS / 5; i++)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    send_sample(16'($urandom));
                end
                else
                begin
                    send_load($urandom_range(0, 63), $urandom_range(0, 15), pick_coef());
                end
            end
            no_idle = 1'b0;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* gammatone_filterbank.f */
sv/gtf_pkg.sv
sv/gtf_front.sv
sv/gtf_back.sv
sv/gammatone_filterbank.sv
tb/sv/gammatone_filterbank_checker.sv
tb/sv/gammatone_filterbank_test.sv
